>>> rtl/core/pidff_pkg.sv
// ----------------------------------------------------------------------------
// pidff_pkg: shared types and helpers for the feedforward velocity loop
// Widths of the datapath, the register map and the saturation and Q8.8
// truncation helpers used by more than one file.
// ----------------------------------------------------------------------------
package pidff_pkg;

	localparam int GainW    = 16;
	localparam int SpeedW   = 16;
	localparam int WindowW  = 16;
	localparam int ErrW     = SpeedW + 1;
	localparam int DerivW   = ErrW + 1;
	localparam int SumW     = 32;
	localparam int DriveW   = 32;
	localparam int ProdW    = 48;
	localparam int QFrac    = 8;
	localparam int TermW    = ProdW - QFrac;
	localparam int PsumW    = TermW + 1;
	localparam int OffW     = GainW + 2;
	localparam int TotalW   = PsumW + 3;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 16;

	typedef logic signed [GainW-1:0]   gain_t;
	typedef logic signed [SpeedW-1:0]  speed_t;
	typedef logic        [WindowW-1:0] window_t;
	typedef logic signed [ErrW-1:0]    error_t;
	typedef logic        [ErrW-1:0]    mag_t;
	typedef logic signed [DerivW-1:0]  deriv_t;
	typedef logic signed [SumW-1:0]    sum_t;
	typedef logic signed [DriveW-1:0]  drive_t;
	typedef logic signed [ProdW-1:0]   prod_t;
	typedef logic signed [TermW-1:0]   term_t;
	typedef logic signed [PsumW-1:0]   psum_t;
	typedef logic signed [OffW-1:0]    off_t;
	typedef logic signed [TotalW-1:0]  total_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_GAIN_P          = 3'd0,
		REG_GAIN_I          = 3'd1,
		REG_GAIN_D          = 3'd2,
		REG_GAIN_V          = 3'd3,
		REG_OFFSET_GRAVITY  = 3'd4,
		REG_OFFSET_STATIC   = 3'd5,
		REG_INTEGRAL_WINDOW = 3'd6
	} cfg_reg_t;

	// Error terms handed from the integrator to the gain stage.
	typedef struct packed {
		error_t error;
		deriv_t deriv;
		sum_t   sum;
	} err_terms_t;

	localparam total_t SatMax = {{(TotalW-DriveW+1){1'b0}}, {(DriveW-1){1'b1}}};
	localparam total_t SatMin = {{(TotalW-DriveW+1){1'b1}}, {(DriveW-1){1'b0}}};
	localparam prod_t  QRound = prod_t'((1 << QFrac) - 1);

	// Clamp a wide signed value into the signed 32-bit range.
	function automatic drive_t sat32(input total_t v);
		drive_t r;
		if (v > SatMax) begin
			r = SatMax[DriveW-1:0];
		end else if (v < SatMin) begin
			r = SatMin[DriveW-1:0];
		end else begin
			r = v[DriveW-1:0];
		end
		return r;
	endfunction

	// Divide a Q8.8 product by 256, rounding toward zero.
	function automatic term_t trunc_q8(input prod_t p);
		prod_t adj;
		adj = p + (p[ProdW-1] ? QRound : prod_t'(0));
		return adj[ProdW-1:QFrac];
	endfunction

endpackage

>>> rtl/core/pidff_sample_if.sv
// ----------------------------------------------------------------------------
// pidff_sample_if: input sample channel
// Carries one measured and one target speed per beat.
// ----------------------------------------------------------------------------
interface pidff_sample_if;
	logic               valid;
	logic               ready;
	pidff_pkg::speed_t  measured_speed;
	pidff_pkg::speed_t  target_speed;

	modport source (output valid, output measured_speed, output target_speed, input ready);
	modport sink (input valid, input measured_speed, input target_speed, output ready);
endinterface

>>> rtl/core/pidff_result_if.sv
// ----------------------------------------------------------------------------
// pidff_result_if: controller output channel
// Carries one saturated drive value per beat.
// ----------------------------------------------------------------------------
interface pidff_result_if;
	logic               valid;
	logic               ready;
	pidff_pkg::drive_t  drive;

	modport source (output valid, output drive, input ready);
	modport sink (input valid, input drive, output ready);
endinterface

>>> rtl/core/pidff_cfg_if.sv
// ----------------------------------------------------------------------------
// pidff_cfg_if: register write channel
// One register index and its write data per beat.
// ----------------------------------------------------------------------------
interface pidff_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [pidff_pkg::CfgIdxW-1:0]       index;
	logic [pidff_pkg::CfgDataW-1:0]      data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/pidff_integ.sv
// ----------------------------------------------------------------------------
// pidff_integ: error, windowed integral and derivative
// Holds the previous error and the integral accumulator; both update once
// per beat that moves from the input stage into the gain stage.
// ----------------------------------------------------------------------------
module pidff_integ (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  pidff_pkg::speed_t      measured,
	input  pidff_pkg::speed_t      target,
	input  pidff_pkg::window_t     window,
	output pidff_pkg::err_terms_t  terms
);

	pidff_pkg::error_t  last_error_q;
	pidff_pkg::sum_t    error_sum_q;
	pidff_pkg::error_t  error;
	pidff_pkg::mag_t    mag;
	pidff_pkg::total_t  sum_ext;
	pidff_pkg::sum_t    sum_next;
	logic               in_window;

	always_comb begin
		error     = pidff_pkg::error_t'(target) - pidff_pkg::error_t'(measured);
		mag       = error[pidff_pkg::ErrW-1] ? pidff_pkg::mag_t'(-error) : pidff_pkg::mag_t'(error);
		in_window = mag < {1'b0, window};
		sum_ext   = pidff_pkg::total_t'(error_sum_q) + pidff_pkg::total_t'(error);
		sum_next  = in_window ? pidff_pkg::sat32(sum_ext) : '0;
		terms.error = error;
		terms.deriv = pidff_pkg::deriv_t'(error) - pidff_pkg::deriv_t'(last_error_q);
		terms.sum   = sum_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_error_q <= '0;
			error_sum_q  <= '0;
		end else if (advance) begin
			last_error_q <= error;
			error_sum_q  <= sum_next;
		end
	end

	// An error outside the window must leave the accumulator cleared.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && !in_window |=> error_sum_q == '0)
		else $error("integral not cleared outside the window");

	// Without a beat moving forward the loop state must not change.
	assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(error_sum_q) && $stable(last_error_q))
		else $error("integrator state changed without a beat");

	// Every beat that moves on leaves its error behind for the next derivative.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> last_error_q == $past(error))
		else $error("previous error not kept");

endmodule

>>> rtl/core/pid_feedforward_velocity_loop.sv
// ----------------------------------------------------------------------------
// pid_feedforward_velocity_loop: PID velocity controller with feedforward
// Error, windowed integral and derivative, four Q8.8 gain products and a
// gravity, static-friction and velocity feedforward, saturated to 32 bits.
// ----------------------------------------------------------------------------
// The block takes one sample per clock cycle while its pipeline is not blocked
// and returns one drive value per sample, in order. A sample passes the input
// register, error and integrator update, gain multiplies, rounding and
// partial sums, then the final add and saturation in the output register,
// before it is presented on the result channel. The integrator and
// previous-error update is the only loop, which sets the rate at one sample
// per cycle. Each stage holds its beat while the next one is full, so a
// stalled result only blocks input once the pipeline has filled up. Register
// writes are taken on every cycle and should be made while the pipeline is
// empty.
module pid_feedforward_velocity_loop (
	input  logic    clk,
	input  logic    arst_n,
	pidff_sample_if.sink   sample,
	pidff_result_if.source result,
	pidff_cfg_if.sink      cfg
);

	// Configuration registers
	pidff_pkg::gain_t   gain_p_q, gain_i_q, gain_d_q, gain_v_q;
	pidff_pkg::gain_t   offset_gravity_q, offset_static_q;
	pidff_pkg::window_t integral_window_q;

	// Pipeline
	logic                  v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic                  rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_out;
	pidff_pkg::speed_t     measured_s1, target_s1, target_s2, target_s3;
	pidff_pkg::err_terms_t terms;
	pidff_pkg::error_t     error_s2;
	pidff_pkg::deriv_t     deriv_s2;
	pidff_pkg::sum_t       sum_s2;
	pidff_pkg::prod_t      prod_p_s3, prod_i_s3, prod_d_s3, prod_v_s3;
	pidff_pkg::prod_t      prod_p, prod_i, prod_d, prod_v;
	pidff_pkg::psum_t      pd_s4, iv_s4;
	pidff_pkg::off_t       off_s4, static_term;
	pidff_pkg::total_t     total;
	pidff_pkg::drive_t     drive_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q          <= '0;
			gain_i_q          <= '0;
			gain_d_q          <= '0;
			gain_v_q          <= '0;
			offset_gravity_q  <= '0;
			offset_static_q   <= '0;
			integral_window_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				pidff_pkg::REG_GAIN_P:          gain_p_q          <= cfg.data;
				pidff_pkg::REG_GAIN_I:          gain_i_q          <= cfg.data;
				pidff_pkg::REG_GAIN_D:          gain_d_q          <= cfg.data;
				pidff_pkg::REG_GAIN_V:          gain_v_q          <= cfg.data;
				pidff_pkg::REG_OFFSET_GRAVITY:  offset_gravity_q  <= cfg.data;
				pidff_pkg::REG_OFFSET_STATIC:   offset_static_q   <= cfg.data;
				pidff_pkg::REG_INTEGRAL_WINDOW: integral_window_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// A stage can take a beat when it is empty or its beat moves on.
	assign rdy_out      = !out_valid_q || result.ready;
	assign rdy_s4       = !v_s4 || rdy_out;
	assign rdy_s3       = !v_s3 || rdy_s4;
	assign rdy_s2       = !v_s2 || rdy_s3;
	assign rdy_s1       = !v_s1 || rdy_s2;
	assign sample.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= sample.valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
			if (rdy_out) begin
				out_valid_q <= v_s4;
			end
		end
	end

	pidff_integ u_integ (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (v_s1 && rdy_s2),
		.measured (measured_s1),
		.target   (target_s1),
		.window   (integral_window_q),
		.terms    (terms)
	);

	always_comb begin
		prod_p = pidff_pkg::prod_t'(gain_p_q) * pidff_pkg::prod_t'(error_s2);
		prod_i = pidff_pkg::prod_t'(gain_i_q) * pidff_pkg::prod_t'(sum_s2);
		prod_d = pidff_pkg::prod_t'(gain_d_q) * pidff_pkg::prod_t'(deriv_s2);
		prod_v = pidff_pkg::prod_t'(gain_v_q) * pidff_pkg::prod_t'(target_s2);
		if (target_s3 > 0) begin
			static_term = pidff_pkg::off_t'(offset_static_q);
		end else if (target_s3 < 0) begin
			static_term = -pidff_pkg::off_t'(offset_static_q);
		end else begin
			static_term = '0;
		end
		total = pidff_pkg::total_t'(pd_s4) + pidff_pkg::total_t'(iv_s4)
			+ pidff_pkg::total_t'(off_s4);
	end

	always_ff @(posedge clk) begin
		if (sample.valid && rdy_s1) begin
			measured_s1 <= sample.measured_speed;
			target_s1   <= sample.target_speed;
		end
		if (v_s1 && rdy_s2) begin
			error_s2  <= terms.error;
			deriv_s2  <= terms.deriv;
			sum_s2    <= terms.sum;
			target_s2 <= target_s1;
		end
		if (v_s2 && rdy_s3) begin
			prod_p_s3 <= prod_p;
			prod_i_s3 <= prod_i;
			prod_d_s3 <= prod_d;
			prod_v_s3 <= prod_v;
			target_s3 <= target_s2;
		end
		if (v_s3 && rdy_s4) begin
			pd_s4  <= pidff_pkg::psum_t'(pidff_pkg::trunc_q8(prod_p_s3))
				+ pidff_pkg::psum_t'(pidff_pkg::trunc_q8(prod_d_s3));
			iv_s4  <= pidff_pkg::psum_t'(pidff_pkg::trunc_q8(prod_i_s3))
				+ pidff_pkg::psum_t'(pidff_pkg::trunc_q8(prod_v_s3));
			off_s4 <= pidff_pkg::off_t'(offset_gravity_q) + static_term;
		end
		if (v_s4 && rdy_out) begin
			drive_q <= pidff_pkg::sat32(total);
		end
	end

	assign result.valid = out_valid_q;
	assign result.drive = drive_q;

	// With the output register empty every stage can move, so input is open.
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> sample.ready)
		else $error("input blocked with an empty output register");

	// A result only appears from a beat that sat in the last stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(v_s4))
		else $error("result raised without a beat in the last stage");

	// A blocked beat in the gain stage keeps its operands.
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !rdy_s3 |=> v_s2 && $stable(error_s2) && $stable(sum_s2))
		else $error("stalled beat lost in the gain stage");

endmodule
